### rtl/core/nta_pkg.sv
// shared types, constants and helper functions for the number to ascii text core
`timescale 1ns / 1ps
package nta_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CharWidth  = 8;
  localparam int unsigned PowWidth   = 34;

  localparam logic [3:0] DecTopPos = 4'd9;
  localparam logic [3:0] HexTopPos = 4'd7;
  localparam logic [1:0] TopStep   = 2'd3;

  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiX    = 8'h78;
  localparam logic [7:0] AsciiA    = 8'h41;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PFX0,
    S_PFXX,
    S_CALC,
    S_EMIT
  } nta_state_t;

  typedef enum logic [1:0] {
    CH_ZERO,
    CH_X,
    CH_DIGIT
  } nta_char_sel_t;

  typedef struct packed {
    logic          load;
    logic          calc;
    logic          put_char;
    nta_char_sel_t char_sel;
    logic          advance;
  } nta_cmd_t;

  typedef struct packed {
    logic radix;
    logic step_zero;
    logic pos_zero;
    logic out_free;
    logic emit_need;
  } nta_sts_t;

  function automatic logic [PowWidth-1:0] pow10(input logic [3:0] pos);
    logic [PowWidth-1:0] p;
    case (pos)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      default: p = 34'd0;
    endcase
    return p;
  endfunction

  function automatic logic [CharWidth-1:0] digit_code(input logic [3:0] d);
    logic [CharWidth-1:0] c;
    if (d > 4'd9) begin
      c = AsciiA + {4'd0, d} - 8'd10;
    end else begin
      c = AsciiZero + {4'd0, d};
    end
    return c;
  endfunction

endpackage

### rtl/core/nta_in_if.sv
// request channel carrying the number to convert
`timescale 1ns / 1ps
interface nta_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

### rtl/core/nta_out_if.sv
// request channel carrying one ascii character of the text
`timescale 1ns / 1ps
interface nta_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink (input valid, input char_code, input is_last, output ready);
endinterface

### rtl/core/nta_ctrl.sv
// controller state machine sequencing prefix, digit extraction and emission
`timescale 1ns / 1ps
module nta_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  nta_pkg::nta_sts_t sts,
  output nta_pkg::nta_cmd_t cmd
);
  import nta_pkg::*;

  nta_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.calc     = 1'b0;
    cmd.put_char = 1'b0;
    cmd.char_sel = CH_DIGIT;
    cmd.advance  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.radix ? S_PFX0 : S_CALC;
        end
      end
      S_PFX0: begin
        cmd.char_sel = CH_ZERO;
        if (sts.out_free) begin
          cmd.put_char = 1'b1;
          state_nxt    = S_PFXX;
        end
      end
      S_PFXX: begin
        cmd.char_sel = CH_X;
        if (sts.out_free) begin
          cmd.put_char = 1'b1;
          state_nxt    = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        // hex digits come from a nibble shift, decimal ones from four trial subtractions
        if (sts.radix || sts.step_zero) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!sts.emit_need) begin
          cmd.advance = 1'b1;
          state_nxt   = S_CALC;
        end else if (sts.out_free) begin
          cmd.put_char = 1'b1;
          if (sts.pos_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_CALC;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/nta_datapath.sv
// datapath: radix register, digit extraction and output character register
`timescale 1ns / 1ps
module nta_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic [31:0]       in_value,
  input  nta_pkg::nta_cmd_t cmd,
  output nta_pkg::nta_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_char_code,
  output logic              out_is_last
);
  import nta_pkg::*;

  logic                  radix_r;
  logic [ValueWidth-1:0] value_r, value_nxt;
  logic [3:0]            pos_r, pos_nxt;
  logic [1:0]            step_r, step_nxt;
  logic [3:0]            digit_r, digit_nxt;
  logic                  started_r, started_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CharWidth-1:0]  char_r, char_nxt;
  logic                  last_r, last_nxt;

  logic [PowWidth-1:0]   trial_w;
  logic [PowWidth-1:0]   value_ext;
  logic [PowWidth-1:0]   diff;
  logic                  fits;

  assign value_ext = {{(PowWidth-ValueWidth){1'b0}}, value_r};
  // current power of ten scaled by the bit weight under trial
  assign trial_w   = pow10(pos_r) << step_r;
  assign diff      = value_ext - trial_w;
  assign fits      = value_ext >= trial_w;

  assign sts.radix     = radix_r;
  assign sts.step_zero = (step_r == 2'd0);
  assign sts.pos_zero  = (pos_r == 4'd0);
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.emit_need = started_r || (digit_r != 4'd0) || (pos_r == 4'd0);

  always_comb begin
    value_nxt     = value_r;
    pos_nxt       = pos_r;
    step_nxt      = step_r;
    digit_nxt     = digit_r;
    started_nxt   = started_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.load) begin
      value_nxt   = in_value;
      pos_nxt     = radix_r ? HexTopPos : DecTopPos;
      step_nxt    = TopStep;
      digit_nxt   = 4'd0;
      started_nxt = 1'b0;
    end

    if (cmd.calc) begin
      if (radix_r) begin
        digit_nxt = value_r[ValueWidth-1 -: 4];
        value_nxt = value_r << 4;
      end else begin
        if (fits) begin
          value_nxt         = diff[ValueWidth-1:0];
          digit_nxt[step_r] = 1'b1;
        end
        step_nxt = step_r - 2'd1;
      end
    end

    if (cmd.put_char) begin
      out_valid_nxt = 1'b1;
      case (cmd.char_sel)
        CH_ZERO: begin
          char_nxt = AsciiZero;
          last_nxt = 1'b0;
        end
        CH_X: begin
          char_nxt = AsciiX;
          last_nxt = 1'b0;
        end
        default: begin
          char_nxt    = digit_code(digit_r);
          last_nxt    = (pos_r == 4'd0);
          started_nxt = 1'b1;
        end
      endcase
    end

    if (cmd.advance) begin
      pos_nxt   = pos_r - 4'd1;
      digit_nxt = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        radix_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r   <= value_nxt;
    pos_r     <= pos_nxt;
    step_r    <= step_nxt;
    digit_r   <= digit_nxt;
    started_r <= started_nxt;
    char_r    <= char_nxt;
    last_r    <= last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = char_r;
  assign out_is_last   = last_r;

endmodule

### rtl/core/number_to_ascii_text_core.sv
// top level of the number to ascii text converter
`timescale 1ns / 1ps
// Converts one 32-bit unsigned number per request into ASCII text, most significant
// character first, leading zeros suppressed, is_last set on the final character.
// cfg_wdata = 0 gives decimal (1 to 10 digits), 1 gives "0x" and 1 to 8 uppercase hex
// digits. One number is worked at a time and every digit position is walked, even a
// suppressed leading zero. A decimal position takes four trial subtractions against
// a power-of-ten table and then an emit step; a hex position takes a shift of the
// top nibble and then an emit step, after the two prefix characters. A receiver
// holding off a character stalls the walk until the output register is free. The
// last character sits in the output register while the next number is accepted.
// Write the mode only while no conversion is in flight.
module number_to_ascii_text_core (
  input  logic      clk,
  input  logic      rst_n,
  nta_in_if.sink    in_chan,
  nta_out_if.source out_chan,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);
  import nta_pkg::*;

  nta_cmd_t cmd;
  nta_sts_t sts;

  nta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nta_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_value      (in_chan.value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_char_code (out_chan.char_code),
    .out_is_last   (out_chan.is_last)
  );

endmodule
